// ===== src/ldtw_pkg.sv =====
// ============================================================================
// ldtw_pkg: shared constants, types and helpers for the DTW layer unit
// Sizes of the cost tables, field widths, register indexes and the
// per-cell control word that travels down the pipeline.
// ============================================================================
package ldtw_pkg;

    // table geometry
    localparam int MAX_POINTS  = 64;
    localparam int COST_WIDTH  = 32;
    localparam int TABLE_DEPTH = MAX_POINTS * MAX_POINTS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // fixed field widths
    localparam int LAYER_W   = 7;
    localparam int INDEX_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int DIST_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [COST_WIDTH-1:0] COST_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

    // layer numbers with special handling
    localparam logic [LAYER_W-1:0] LAYER_NONE   = LAYER_W'(0);
    localparam logic [LAYER_W-1:0] LAYER_FIRST  = LAYER_W'(1);
    localparam logic [LAYER_W-1:0] LAYER_SECOND = LAYER_W'(2);

    // per-cell control word
    typedef struct packed {
        logic in_table;   // cell lies inside the table, its value gets stored
        logic computed;   // cell value is a sum, otherwise zero
        logic has_prev;   // previous layer minimum takes part
        logic use_cur;    // cell above in the current layer takes part
        logic use_run;    // running minimum along the row takes part
        logic run_start;  // first cell of a row run, minimum restarts at infinity
    } cell_ctrl_t;

    function automatic logic [COST_WIDTH-1:0] min_cost(
        input logic [COST_WIDTH-1:0] a,
        input logic [COST_WIDTH-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== src/ldtw_ram.sv =====
// ============================================================================
// ldtw_ram: generic synchronous RAM
// One write port and two read ports, read data registered under a shared
// read enable. A read of the address being written returns the old data.
// ============================================================================
module ldtw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // registered read ports
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= mem_array[rd_addr_a];
            rd_data_b_reg <= mem_array[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== src/ldtw_cost.sv =====
// ============================================================================
// ldtw_cost: cell value arithmetic
// Merges the running minimum, the previous layer minimum and the cell above,
// then adds the pair distance with saturation at the all-ones maximum.
// ============================================================================
module ldtw_cost (
    input  ldtw_pkg::cell_ctrl_t                ctrl,
    input  logic [ldtw_pkg::COST_WIDTH-1:0]     run_min,
    input  logic [ldtw_pkg::COST_WIDTH-1:0]     prev_min,
    input  logic [ldtw_pkg::COST_WIDTH-1:0]     cur_above,
    input  logic [ldtw_pkg::DIST_W-1:0]         pair_dist,
    output logic [ldtw_pkg::COST_WIDTH-1:0]     cost,
    output logic                                saturated,
    output logic [ldtw_pkg::COST_WIDTH-1:0]     run_next
);

    logic [ldtw_pkg::COST_WIDTH-1:0] run_base;
    logic [ldtw_pkg::COST_WIDTH-1:0] row_min;
    logic [ldtw_pkg::COST_WIDTH-1:0] prev_term;
    logic [ldtw_pkg::COST_WIDTH-1:0] base;
    logic [ldtw_pkg::COST_WIDTH:0]   sum;

    // running minimum restarts at infinity on the first cell of a run
    assign run_base = ctrl.run_start ? ldtw_pkg::COST_MAX : run_min;
    assign row_min  = ctrl.use_run ? ldtw_pkg::min_cost(run_base, prev_min) : prev_min;
    assign run_next = row_min;

    // pick the base the distance is added to
    always_comb begin
        prev_term = ctrl.has_prev ? row_min : ldtw_pkg::COST_MAX;
        if (ctrl.use_cur) begin
            base = ldtw_pkg::min_cost(prev_term, cur_above);
        end else if (ctrl.has_prev) begin
            base = prev_term;
        end else begin
            base = '0;
        end
    end

    // saturating add
    assign sum = {1'b0, base} + {1'b0, ldtw_pkg::COST_WIDTH'(pair_dist)};

    always_comb begin
        if (ctrl.computed) begin
            saturated = sum[ldtw_pkg::COST_WIDTH];
            cost      = sum[ldtw_pkg::COST_WIDTH] ? ldtw_pkg::COST_MAX
                                                  : sum[ldtw_pkg::COST_WIDTH-1:0];
        end else begin
            saturated = 1'b0;
            cost      = '0;
        end
    end

endmodule

// ===== src/length_constrained_dtw_layer_unit.sv =====
// ============================================================================
// length_constrained_dtw_layer_unit: one layer of a length-constrained DTW table
// Cells stream in row-major order; each returns its table value. The previous
// and current layer live in two RAM banks that swap roles on a new layer.
// ============================================================================
//
//  channel  | dir | ports                                   | transfer when
//  ---------+-----+-----------------------------------------+--------------------
//  cell in  | in  | s_layer s_row s_col s_dist_req          | s_valid & s_ready
//  cost out | out | m_cost m_saturated                      | m_valid & m_ready
//  config   | in  | cfg_wr_index cfg_wr_data                | cfg_wr_en
//
//  One cell per cycle while the output flows and no new layer waits; the steps are
//  RAM read, previous-layer minimum, cost add into the output register.
//  A cell with a new layer number waits until both compute stages are empty,
//  since its reads target the bank being written.
//  The cell above comes forwarded from in-flight writes, so no stall is needed.
//  Reset clears control state only; table RAMs need no clearing pass.
//  A stalled output holds the pipeline; each stage buffers one transaction.
//
module length_constrained_dtw_layer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [ldtw_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [ldtw_pkg::COUNT_W-1:0]        cfg_wr_data,
    // cell input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ldtw_pkg::LAYER_W-1:0]        s_layer,
    input  logic [ldtw_pkg::INDEX_W-1:0]        s_row,
    input  logic [ldtw_pkg::INDEX_W-1:0]        s_col,
    input  logic [ldtw_pkg::DIST_W-1:0]         s_dist_req,
    // cost output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ldtw_pkg::COST_WIDTH-1:0]     m_cost,
    output logic                                m_saturated
);

    localparam int AW = ldtw_pkg::ADDR_W;
    localparam int CW = ldtw_pkg::COST_WIDTH;

    // configuration registers
    logic [ldtw_pkg::COUNT_W-1:0] row_count_reg;
    logic [ldtw_pkg::COUNT_W-1:0] column_count_reg;

    // layer tracking
    logic [ldtw_pkg::LAYER_W-1:0] active_layer_reg;
    logic                         bank_reg;
    logic [CW-1:0]                running_min_reg;

    // stage 1 (read data arrives)
    logic                         v1_reg;
    ldtw_pkg::cell_ctrl_t         ctrl1_reg;
    logic [AW-1:0]                here1_reg;
    logic [AW-1:0]                above1_reg;
    logic [ldtw_pkg::DIST_W-1:0]  dist1_reg;
    logic                         bank1_reg;
    logic                         fwd_hit1_reg;
    logic [CW-1:0]                fwd_data1_reg;

    // stage 2 (cost add)
    logic                         v2_reg;
    ldtw_pkg::cell_ctrl_t         ctrl2_reg;
    logic [AW-1:0]                here2_reg;
    logic [ldtw_pkg::DIST_W-1:0]  dist2_reg;
    logic [CW-1:0]                pmin2_reg;
    logic [CW-1:0]                cur2_reg;

    // output register
    logic                         m_valid_reg;
    logic [CW-1:0]                m_cost_reg;
    logic                         m_saturated_reg;

    // handshake and flow
    logic                         accept;
    logic                         adv1;
    logic                         adv2;
    logic                         layer_change;

    // stage 0 decode
    ldtw_pkg::cell_ctrl_t         ctrl_in;
    logic                         in_table;
    logic                         row_zero;
    logic [ldtw_pkg::LAYER_W-1:0] col_p1;
    logic [AW-1:0]                row_base;
    logic [AW-1:0]                here_in;
    logic [AW-1:0]                above_in;
    logic [AW-1:0]                prev_a_addr;
    logic [AW-1:0]                prev_b_addr;
    logic                         cur_bank_in;

    // RAM ports
    logic [AW-1:0]                b0_raddr_a;
    logic [AW-1:0]                b1_raddr_a;
    logic [CW-1:0]                b0_rdata_a;
    logic [CW-1:0]                b0_rdata_b;
    logic [CW-1:0]                b1_rdata_a;
    logic [CW-1:0]                b1_rdata_b;
    logic                         wr_en;
    logic [CW-1:0]                wr_data;

    // stage 1 selection
    logic [CW-1:0]                cur_rd;
    logic [CW-1:0]                prev_a_rd;
    logic [CW-1:0]                prev_b_rd;
    logic [CW-1:0]                cur_fwd;

    // stage 2 results
    logic                         sat2;
    logic [CW-1:0]                run_next;

    // pipeline flow control
    assign adv2         = v2_reg && (!m_valid_reg || m_ready);
    assign adv1         = v1_reg && (!v2_reg || adv2);
    assign layer_change = (s_layer != active_layer_reg);
    assign s_ready      = (!v1_reg || adv1) && !(layer_change && (v1_reg || v2_reg));
    assign accept       = s_valid && s_ready;

    // cell classification
    always_comb begin
        in_table = ({1'b0, s_row} < row_count_reg) && ({1'b0, s_col} < column_count_reg)
                   && (32'(s_row) < 32'(ldtw_pkg::MAX_POINTS))
                   && (32'(s_col) < 32'(ldtw_pkg::MAX_POINTS));
        row_zero = (s_row == '0);
        col_p1   = ldtw_pkg::LAYER_W'(s_col) + ldtw_pkg::LAYER_W'(1);

        ctrl_in          = '0;
        ctrl_in.in_table = in_table;
        ctrl_in.use_cur  = !row_zero;
        if (s_layer == ldtw_pkg::LAYER_NONE) begin
            ctrl_in.computed = 1'b0;
        end else if (s_layer == ldtw_pkg::LAYER_FIRST) begin
            ctrl_in.computed = (s_col == '0);
        end else if (s_layer == ldtw_pkg::LAYER_SECOND) begin
            ctrl_in.computed = (s_col != '0);
            ctrl_in.has_prev = 1'b1;
        end else begin
            ctrl_in.computed  = (col_p1 >= s_layer);
            ctrl_in.has_prev  = 1'b1;
            ctrl_in.use_run   = 1'b1;
            ctrl_in.run_start = (col_p1 == s_layer);
        end
        ctrl_in.computed = ctrl_in.computed && in_table;
    end

    // table addresses
    always_comb begin
        row_base = AW'(s_row) * AW'(ldtw_pkg::MAX_POINTS);
        here_in  = row_base + AW'(s_col);
        above_in = here_in - AW'(ldtw_pkg::MAX_POINTS);
        if (s_layer == ldtw_pkg::LAYER_SECOND) begin
            prev_a_addr = row_zero ? '0 : row_base - AW'(ldtw_pkg::MAX_POINTS);
            prev_b_addr = row_base;
        end else begin
            prev_a_addr = row_zero ? here_in - AW'(1) : above_in - AW'(1);
            prev_b_addr = here_in - AW'(1);
        end
    end

    // bank roles: current bank reads the cell above, the other the previous layer
    assign cur_bank_in = layer_change ? !bank_reg : bank_reg;
    assign b0_raddr_a  = cur_bank_in ? prev_a_addr : above_in;
    assign b1_raddr_a  = cur_bank_in ? above_in : prev_a_addr;

    assign wr_en = adv2 && ctrl2_reg.in_table;

    ldtw_ram #(
        .WIDTH (CW),
        .DEPTH (ldtw_pkg::TABLE_DEPTH)
    ) u_bank0 (
        .aclk      (aclk),
        .wr_en     (wr_en && !bank_reg),
        .wr_addr   (here2_reg),
        .wr_data   (wr_data),
        .rd_en     (accept),
        .rd_addr_a (b0_raddr_a),
        .rd_addr_b (prev_b_addr),
        .rd_data_a (b0_rdata_a),
        .rd_data_b (b0_rdata_b)
    );

    ldtw_ram #(
        .WIDTH (CW),
        .DEPTH (ldtw_pkg::TABLE_DEPTH)
    ) u_bank1 (
        .aclk      (aclk),
        .wr_en     (wr_en && bank_reg),
        .wr_addr   (here2_reg),
        .wr_data   (wr_data),
        .rd_en     (accept),
        .rd_addr_a (b1_raddr_a),
        .rd_addr_b (prev_b_addr),
        .rd_data_a (b1_rdata_a),
        .rd_data_b (b1_rdata_b)
    );

    // stage 1 read data steering and forwarding of the cell above
    assign cur_rd    = bank1_reg ? b1_rdata_a : b0_rdata_a;
    assign prev_a_rd = bank1_reg ? b0_rdata_a : b1_rdata_a;
    assign prev_b_rd = bank1_reg ? b0_rdata_b : b1_rdata_b;

    always_comb begin
        if (wr_en && (here2_reg == above1_reg)) begin
            cur_fwd = wr_data;
        end else if (fwd_hit1_reg) begin
            cur_fwd = fwd_data1_reg;
        end else begin
            cur_fwd = cur_rd;
        end
    end

    // stage 2 arithmetic
    ldtw_cost u_cost (
        .ctrl      (ctrl2_reg),
        .run_min   (running_min_reg),
        .prev_min  (pmin2_reg),
        .cur_above (cur2_reg),
        .pair_dist (dist2_reg),
        .cost      (wr_data),
        .saturated (sat2),
        .run_next  (run_next)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= ldtw_pkg::COUNT_RESET;
            column_count_reg <= ldtw_pkg::COUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                ldtw_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_wr_data;
                ldtw_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // layer tracking and running minimum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_layer_reg <= ldtw_pkg::LAYER_NONE;
            bank_reg         <= 1'b0;
            running_min_reg  <= ldtw_pkg::COST_MAX;
        end else begin
            if (accept && layer_change) begin
                active_layer_reg <= s_layer;
                bank_reg         <= !bank_reg;
            end
            if (adv2 && ctrl2_reg.use_run && ctrl2_reg.computed) begin
                running_min_reg <= run_next;
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                v1_reg <= 1'b1;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end
            if (adv1) begin
                v2_reg <= 1'b1;
            end else if (adv2) begin
                v2_reg <= 1'b0;
            end
            if (adv2) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            ctrl1_reg     <= ctrl_in;
            here1_reg     <= here_in;
            above1_reg    <= above_in;
            dist1_reg     <= s_dist_req;
            bank1_reg     <= cur_bank_in;
            fwd_hit1_reg  <= wr_en && (here2_reg == above_in);
            fwd_data1_reg <= wr_data;
        end
    end

    // stage 2 payload
    always_ff @(posedge aclk) begin
        if (adv1) begin
            ctrl2_reg <= ctrl1_reg;
            here2_reg <= here1_reg;
            dist2_reg <= dist1_reg;
            pmin2_reg <= ldtw_pkg::min_cost(prev_a_rd, prev_b_rd);
            cur2_reg  <= cur_fwd;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (adv2) begin
            m_cost_reg      <= wr_data;
            m_saturated_reg <= sat2;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cost      = m_cost_reg;
    assign m_saturated = m_saturated_reg;

endmodule
